FILE: src/rpd_pkg.sv
`default_nettype none

package rpd_pkg;

   // Field widths
   localparam int DATA_W = 32;
   // Internal coordinate width: Q16.16 input scaled to 32 fraction bits plus CORDIC growth
   localparam int XW = 50;
   // Angle accumulator width, Q30 radians with headroom
   localparam int ZW = 33;
   // Folded angle magnitude, at most 90 degrees in 1/65536 degree units
   localparam int MAG_W = 23;

   // Angle units: 1/65536 degree
   localparam int unsigned UNITS_90 = 5898240;
   localparam int unsigned UNITS_180 = 11796480;
   localparam int unsigned UNITS_360 = 23592960;

   // 360 degrees = 45 * 2^19 units: reduce the upper bits modulo 45
   localparam int unsigned MOD_DIV = 45;
   localparam int unsigned MOD_SHIFT = 19;
   // Offset making the 13-bit signed quotient non-negative, a multiple of 45
   localparam int unsigned QUOT_OFFSET = 4140;
   // floor(2^16 / 45), never over-estimates the quotient
   localparam int unsigned RECIP_45 = 1456;

   // round(pi/180 * 2^40), split into two narrow halves
   localparam longint unsigned DEG_TO_RAD_Q40 = 64'd19190098069;
   localparam int CONV_SPLIT = 17;
   localparam int unsigned CONV_HI = 32'(DEG_TO_RAD_Q40 >> CONV_SPLIT);
   localparam int unsigned CONV_LO = 32'(DEG_TO_RAD_Q40 & ((64'd1 << CONV_SPLIT) - 64'd1));
   localparam int CONV_HI_W = 18;
   localparam int CONV_LO_W = 17;

   // CORDIC gain limit in Q30
   localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;
   localparam int PROD_W = 62;

   // Coordinates and angle handed from cell to cell
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } crd_vec_type;

   // Arctangent of 2^-i in Q30 radians
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:  val = 30'd843314856;
         5'd1:  val = 30'd497837829;
         5'd2:  val = 30'd263043836;
         5'd3:  val = 30'd133525158;
         5'd4:  val = 30'd67021686;
         5'd5:  val = 30'd33543515;
         5'd6:  val = 30'd16775850;
         5'd7:  val = 30'd8388437;
         5'd8:  val = 30'd4194282;
         5'd9:  val = 30'd2097149;
         5'd10: val = 30'd1048576;
         5'd11: val = 30'd524288;
         5'd12: val = 30'd262144;
         5'd13: val = 30'd131072;
         5'd14: val = 30'd65536;
         5'd15: val = 30'd32768;
         5'd16: val = 30'd16384;
         5'd17: val = 30'd8192;
         5'd18: val = 30'd4096;
         5'd19: val = 30'd2048;
         5'd20: val = 30'd1024;
         5'd21: val = 30'd512;
         5'd22: val = 30'd256;
         5'd23: val = 30'd128;
         5'd24: val = 30'd64;
         5'd25: val = 30'd32;
         5'd26: val = 30'd16;
         5'd27: val = 30'd8;
         5'd28: val = 30'd4;
         5'd29: val = 30'd2;
         5'd30: val = 30'd1;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: src/rpd_if.sv
`default_nettype none

// Request channel: point and angle
interface rpd_req_if import rpd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] x_in;
   logic signed [DATA_W-1:0] y_in;
   logic signed [DATA_W-1:0] angle_deg;

   modport source (output valid, output x_in, output y_in, output angle_deg, input ready);
   modport sink (input valid, input x_in, input y_in, input angle_deg, output ready);
endinterface

// Response channel: rotated point
interface rpd_rsp_if import rpd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] x_out;
   logic signed [DATA_W-1:0] y_out;

   modport source (output valid, output x_out, output y_out, input ready);
   modport sink (input valid, input x_out, input y_out, output ready);
endinterface

`default_nettype wire

FILE: src/rotate_point_by_degrees.sv
// Pipeline: the front stages, CORDIC_STAGES micro-rotation cells and the response register.
// Throughput: one request per cycle unless the response stalls; each CORDIC cell holds one point and passes it on.
// Every stage moves when empty or when its successor moves, so bubbles close up under stall.
// Reset (synchronous, active high) clears all valid flags; data registers are not reset.
`default_nettype none

module rotate_point_by_degrees import rpd_pkg::*; #(
   parameter int CORDIC_STAGES = 24
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rpd_req_if.sink    req_if,
   rpd_rsp_if.source  rsp_if
);

   localparam int N = CORDIC_STAGES;

   crd_vec_type vec [0:N];
   logic        valid [0:N];
   logic        en [0:N];

   // Angle reduction, fold, pre-scale and angle conversion
   rpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .x_in      (req_if.x_in),
      .y_in      (req_if.y_in),
      .angle_deg (req_if.angle_deg),
      .up_en     (req_if.ready),
      .out_valid (valid[0]),
      .out_vec   (vec[0]),
      .down_en   (en[0])
   );

   // Row of micro-rotation cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      rpd_cell #(.SHIFT(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_vec    (vec[i]),
         .up_en     (en[i]),
         .out_valid (valid[i+1]),
         .out_vec   (vec[i+1]),
         .down_en   (en[i+1])
      );
   end

   // Rounding, saturation and the response register
   rpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid[N]),
      .in_vec     (vec[N]),
      .up_en      (en[N]),
      .out_valid  (rsp_if.valid),
      .x_out      (rsp_if.x_out),
      .y_out      (rsp_if.y_out),
      .down_ready (rsp_if.ready)
   );

endmodule

`default_nettype wire

FILE: src/rpd_front.sv
`default_nettype none

module rpd_front import rpd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic signed [DATA_W-1:0] x_in,
   input  wire logic signed [DATA_W-1:0] y_in,
   input  wire logic signed [DATA_W-1:0] angle_deg,
   output      logic                     up_en,
   output      logic                     out_valid,
   output      crd_vec_type              out_vec,
   input  wire logic                     down_en
);

   localparam int QW = DATA_W - MOD_SHIFT;    // quotient bits of the angle
   localparam int NW = QW + 1;                // offset quotient bits
   localparam int RW = 6;                     // remainder below 45
   localparam int RED_W = RW + MOD_SHIFT;     // reduced angle, [0, 360) degrees
   localparam int FOLD_W = RED_W + 2;         // signed working width for the fold
   localparam int PH_W = MAG_W + CONV_HI_W;
   localparam int PL_W = MAG_W + CONV_LO_W;
   localparam int SUM_W = PH_W + CONV_SPLIT + 1;
   localparam int QE_W = 8;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   // Stage enables: a stage moves when it is empty or its successor moves
   assign en5 = !v5_ff || down_en;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign up_en = en1;

   // Stage 1: split the angle, estimate quotient by 45, pre-scale products
   logic [NW-1:0]              n_in, n1_ff;
   logic [QE_W-1:0]            qe_in, qe1_ff;
   logic [MOD_SHIFT-1:0]       low1_ff;
   logic signed [PROD_W-1:0]   px_in, py_in, px1_ff, py1_ff;
   logic [NW+11-1:0]           qprod;

   always_comb begin
      n_in = {angle_deg[DATA_W-1], angle_deg[DATA_W-1:MOD_SHIFT]} + NW'(QUOT_OFFSET);
      qprod = (NW+11)'(n_in) * (NW+11)'(RECIP_45);
      qe_in = QE_W'(qprod >> 16);
      px_in = x_in * GAIN_Q30;
      py_in = y_in * GAIN_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
      if (en1) begin
         n1_ff   <= n_in;
         qe1_ff  <= qe_in;
         low1_ff <= angle_deg[MOD_SHIFT-1:0];
         px1_ff  <= px_in;
         py1_ff  <= py_in;
      end
   end

   // Stage 2: finish the modulo, round the pre-scaled coordinates
   logic [NW-1:0]        rem0;
   logic [RW-1:0]        rem;
   logic [RED_W-1:0]     r_in, r2_ff;
   logic signed [XW-1:0] xs_in, ys_in, xs2_ff, ys2_ff;
   logic signed [PROD_W-1:0] px_rnd, py_rnd;

   always_comb begin
      rem0 = n1_ff - NW'(NW'(qe1_ff) * NW'(MOD_DIV));
      if (rem0 >= NW'(MOD_DIV)) begin
         rem = RW'(rem0 - NW'(MOD_DIV));
      end else begin
         rem = RW'(rem0);
      end
      r_in = {rem, low1_ff};
      px_rnd = px1_ff + PROD_W'(signed'(64'sd8192));
      py_rnd = py1_ff + PROD_W'(signed'(64'sd8192));
      xs_in = XW'(px_rnd >>> 14);
      ys_in = XW'(py_rnd >>> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         r2_ff  <= r_in;
         xs2_ff <= xs_in;
         ys2_ff <= ys_in;
      end
   end

   // Stage 3: fold into [-90, 90] degrees, negate the point on a half-turn fold
   logic signed [FOLD_W-1:0] rs, rf;
   logic                     flip;
   logic [MAG_W-1:0]         mag_in, mag3_ff;
   logic                     neg_in, neg3_ff;
   logic signed [XW-1:0]     xs3_in, ys3_in, xs3_ff, ys3_ff;

   always_comb begin
      rs = signed'(FOLD_W'(r2_ff));
      if (r2_ff > RED_W'(UNITS_180)) begin
         rs = rs - signed'(FOLD_W'(UNITS_360));
      end
      rf = rs;
      flip = 1'b0;
      if (rs > signed'(FOLD_W'(UNITS_90))) begin
         rf = rs - signed'(FOLD_W'(UNITS_180));
         flip = 1'b1;
      end else if (rs < -signed'(FOLD_W'(UNITS_90))) begin
         rf = rs + signed'(FOLD_W'(UNITS_180));
         flip = 1'b1;
      end
      neg_in = rf[FOLD_W-1];
      if (neg_in) begin
         mag_in = MAG_W'(-rf);
      end else begin
         mag_in = MAG_W'(rf);
      end
      xs3_in = flip ? -xs2_ff : xs2_ff;
      ys3_in = flip ? -ys2_ff : ys2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         mag3_ff <= mag_in;
         neg3_ff <= neg_in;
         xs3_ff  <= xs3_in;
         ys3_ff  <= ys3_in;
      end
   end

   // Stage 4: degrees to radians, two narrow partial products
   logic [PH_W-1:0]      ph_in, ph4_ff;
   logic [PL_W-1:0]      pl_in, pl4_ff;
   logic                 neg4_ff;
   logic signed [XW-1:0] xs4_ff, ys4_ff;

   always_comb begin
      ph_in = PH_W'(mag3_ff) * PH_W'(CONV_HI);
      pl_in = PL_W'(mag3_ff) * PL_W'(CONV_LO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
      if (en4) begin
         ph4_ff  <= ph_in;
         pl4_ff  <= pl_in;
         neg4_ff <= neg3_ff;
         xs4_ff  <= xs3_ff;
         ys4_ff  <= ys3_ff;
      end
   end

   // Stage 5: sum, round to Q30 and apply the sign
   logic [SUM_W-1:0]     zsum;
   logic [ZW-1:0]        zmag;
   crd_vec_type          vec_in, vec5_ff;

   always_comb begin
      zsum = (SUM_W'(ph4_ff) << CONV_SPLIT) + SUM_W'(pl4_ff) + (SUM_W'(1) << 25);
      zmag = ZW'(zsum >> 26);
      vec_in.x = xs4_ff;
      vec_in.y = ys4_ff;
      vec_in.z = neg4_ff ? -signed'(zmag) : signed'(zmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en5) begin
         v5_ff <= v4_ff;
      end
      if (en5) begin
         vec5_ff <= vec_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_vec = vec5_ff;

endmodule

`default_nettype wire

FILE: src/rpd_cell.sv
`default_nettype none

module rpd_cell import rpd_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire crd_vec_type in_vec,
   output      logic        up_en,
   output      logic        out_valid,
   output      crd_vec_type out_vec,
   input  wire logic        down_en
);

   logic        v_ff;
   crd_vec_type vec_ff, vec_in;
   logic signed [XW-1:0] dx, dy;
   logic signed [ZW-1:0] ang;

   assign up_en = !v_ff || down_en;

   // One micro-rotation: direction from the sign of the residual angle
   always_comb begin
      dx = in_vec.y >>> SHIFT;
      dy = in_vec.x >>> SHIFT;
      ang = signed'(ZW'(atan_q30(5'(SHIFT))));
      if (!in_vec.z[ZW-1]) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ang;
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_en) begin
         v_ff <= in_valid;
      end
      if (up_en) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = v_ff;
   assign out_vec = vec_ff;

endmodule

`default_nettype wire

FILE: src/rpd_back.sv
`default_nettype none

module rpd_back import rpd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire crd_vec_type              in_vec,
   output      logic                     up_en,
   output      logic                     out_valid,
   output      logic signed [DATA_W-1:0] x_out,
   output      logic signed [DATA_W-1:0] y_out,
   input  wire logic                     down_ready
);

   localparam int RND_W = XW - 16 + 1;

   logic                     v_ff;
   logic signed [DATA_W-1:0] x_ff, y_ff, x_in, y_in;

   // Round half up to Q16.16 and clamp to 32 bits
   function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [XW-1:0] v);
      logic signed [XW:0]      t;
      logic signed [RND_W-1:0] r;
      logic signed [DATA_W-1:0] res;
      t = (XW+1)'(v) + (XW+1)'(signed'(33'sd32768));
      r = RND_W'(t >>> 16);
      if (r > RND_W'(signed'(33'sd2147483647))) begin
         res = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (r < -RND_W'(signed'(33'sd2147483648))) begin
         res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = DATA_W'(r);
      end
      return res;
   endfunction

   assign up_en = !v_ff || down_ready;

   always_comb begin
      x_in = rnd_sat(in_vec.x);
      y_in = rnd_sat(in_vec.y);
   end

   // Output register: hold the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_en) begin
         v_ff <= in_valid;
      end
      if (up_en) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign out_valid = v_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

`default_nettype wire

FILE: src/rpd_checker.sv
`default_nettype none

module rpd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // An empty response register lets the whole row move
   a_ready_empty: assert property (@(posedge clock) !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // A taken response never blocks the request side
   a_ready_flow: assert property (@(posedge clock) rsp_ready |-> req_ready)
      else $error("request stalled while response side ready");

endmodule

bind rotate_point_by_degrees rpd_checker u_rpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready)
);

`default_nettype wire
